// ===== hdl/rse_pkg.sv =====
`timescale 1ns / 1ps
// rse_pkg: shared constants, codes and handshake structs of the rpn stack evaluator
// depends on nothing; used by rse_arith and rpn_stack_evaluator_unit
package rse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_VARS    = 4;
    localparam int VALUE_WIDTH = 48;
    localparam int FRAC_BITS   = 16;

    localparam int SP_W      = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W    = $clog2(STACK_DEPTH);
    localparam int VAR_IDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int ADD_W     = VALUE_WIDTH + 2;
    localparam int NUM_W     = VALUE_WIDTH + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    localparam logic [VALUE_WIDTH-1:0] POS_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] NEG_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

    typedef enum logic [2:0] {
        REQ_PUSH_LIT = 3'd0,
        REQ_PUSH_VAR = 3'd1,
        REQ_ADD      = 3'd2,
        REQ_SUB      = 3'd3,
        REQ_MUL      = 3'd4,
        REQ_DIV      = 3'd5,
        REQ_SET_VAR  = 3'd6,
        REQ_FINISH   = 3'd7
    } req_type_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIV_ZERO  = 2'd3
    } err_code_t;

    typedef struct packed {
        logic      start;
        req_type_t op;
    } arith_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } arith_rsp_t;

endpackage

// ===== hdl/rse_arith.sv =====
`timescale 1ns / 1ps
// rse_arith: saturating add, sub, shift-add multiply and restoring divide
// built around one shared adder under a small sequencer; uses rse_pkg
module rse_arith (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  rse_pkg::arith_req_t                       arith_req,
    input  logic signed [rse_pkg::VALUE_WIDTH-1:0]    lhs,
    input  logic signed [rse_pkg::VALUE_WIDTH-1:0]    rhs,
    output rse_pkg::arith_rsp_t                       arith_rsp,
    output logic signed [rse_pkg::VALUE_WIDTH-1:0]    value
);
    import rse_pkg::*;

    localparam int VW = VALUE_WIDTH;

    typedef enum logic [5:0] {
        A_IDLE   = 6'b000001,
        A_ADDSUB = 6'b000010,
        A_MUL    = 6'b000100,
        A_DIV    = 6'b001000,
        A_SAT    = 6'b010000,
        A_DONE   = 6'b100000
    } arith_state_t;

    arith_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VW-1:0]     lhs_reg, lhs_next;
    logic [VW-1:0]     rhs_reg, rhs_next;
    logic [VW:0]       acc_reg, acc_next;
    logic [VW-1:0]     lo_reg, lo_next;
    logic [VW-1:0]     mcand_reg, mcand_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [VW-1:0]     value_reg, value_next;
    logic              neg_reg, neg_next;
    logic              sub_reg, sub_next;
    logic              div_reg, div_next;
    logic              qover_reg, qover_next;
    logic              dz_reg, dz_next;

    logic [ADD_W-1:0]  add_x, add_y, add_sum;
    logic              add_sub;
    logic [VW:0]       rem_sh;
    logic [VW:0]       mul_t;
    logic              div_ge;
    logic [VW-1:0]     mag_l, mag_r;
    logic [VW-1:0]     lim;
    logic [2*VW-1:0]   prod;
    logic [VW-1:0]     mag_sel;
    logic              over;

    // shared adder
    assign add_sum = add_x + (add_y ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);

    assign rem_sh = {acc_reg[VW-1:0], num_reg[NUM_W-1]};
    assign div_ge = !add_sum[ADD_W-1];
    assign mul_t  = lo_reg[0] ? add_sum[VW:0] : acc_reg;
    assign mag_l  = lhs[VW-1] ? (~lhs + VW'(1)) : lhs;
    assign mag_r  = rhs[VW-1] ? (~rhs + VW'(1)) : rhs;
    assign lim    = neg_reg ? NEG_MIN : POS_MAX;
    assign prod   = {acc_reg[VW-1:0], lo_reg} >> FRAC_BITS;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lhs_next   = lhs_reg;
        rhs_next   = rhs_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        num_next   = num_reg;
        value_next = value_reg;
        neg_next   = neg_reg;
        sub_next   = sub_reg;
        div_next   = div_reg;
        qover_next = qover_reg;
        dz_next    = dz_reg;
        add_x      = '0;
        add_y      = '0;
        add_sub    = 1'b0;
        over       = 1'b0;
        mag_sel    = '0;
        arith_rsp  = '0;

        case (state_reg)
            A_IDLE:
            begin
                if (arith_req.start)
                begin
                    lhs_next   = lhs;
                    rhs_next   = rhs;
                    neg_next   = lhs[VW-1] ^ rhs[VW-1];
                    sub_next   = (arith_req.op == REQ_SUB);
                    div_next   = (arith_req.op == REQ_DIV);
                    acc_next   = '0;
                    qover_next = 1'b0;
                    dz_next    = 1'b0;
                    case (arith_req.op)
                        REQ_ADD, REQ_SUB:
                        begin
                            state_next = A_ADDSUB;
                        end
                        REQ_MUL:
                        begin
                            mcand_next = mag_l;
                            lo_next    = mag_r;
                            cnt_next   = CNT_W'(VW);
                            state_next = A_MUL;
                        end
                        REQ_DIV:
                        begin
                            if (rhs == '0)
                            begin
                                dz_next = 1'b1;
                                if (lhs > 0)
                                    value_next = POS_MAX;
                                else if (lhs < 0)
                                    value_next = NEG_MIN;
                                else
                                    value_next = '0;
                                state_next = A_DONE;
                            end
                            else
                            begin
                                mcand_next = mag_r;
                                num_next   = NUM_W'(mag_l) << FRAC_BITS;
                                lo_next    = '0;
                                cnt_next   = CNT_W'(NUM_W);
                                state_next = A_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = A_IDLE;
                        end
                    endcase
                end
            end
            A_ADDSUB:
            begin
                add_x   = {{2{lhs_reg[VW-1]}}, lhs_reg};
                add_y   = {{2{rhs_reg[VW-1]}}, rhs_reg};
                add_sub = sub_reg;
                if (add_sum[VW] != add_sum[VW-1])
                    value_next = add_sum[VW] ? NEG_MIN : POS_MAX;
                else
                    value_next = add_sum[VW-1:0];
                state_next = A_DONE;
            end
            A_MUL:
            begin
                add_x    = ADD_W'(acc_reg);
                add_y    = ADD_W'(mcand_reg);
                acc_next = mul_t >> 1;
                lo_next  = {mul_t[0], lo_reg[VW-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = A_SAT;
            end
            A_DIV:
            begin
                add_x      = ADD_W'(rem_sh);
                add_y      = ADD_W'(mcand_reg);
                add_sub    = 1'b1;
                acc_next   = div_ge ? add_sum[VW:0] : rem_sh;
                lo_next    = {lo_reg[VW-2:0], div_ge};
                qover_next = qover_reg | lo_reg[VW-1];
                num_next   = num_reg << 1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = A_SAT;
            end
            A_SAT:
            begin
                if (div_reg)
                begin
                    over    = qover_reg || (lo_reg > lim);
                    mag_sel = lo_reg;
                end
                else
                begin
                    over    = prod > (2 * VW)'(lim);
                    mag_sel = prod[VW-1:0];
                end
                if (over)
                    mag_sel = lim;
                value_next = neg_reg ? (~mag_sel + VW'(1)) : mag_sel;
                state_next = A_DONE;
            end
            A_DONE:
            begin
                arith_rsp.done     = 1'b1;
                arith_rsp.div_zero = dz_reg;
                state_next         = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lhs_reg   <= lhs_next;
        rhs_reg   <= rhs_next;
        acc_reg   <= acc_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
        num_reg   <= num_next;
        value_reg <= value_next;
        neg_reg   <= neg_next;
        sub_reg   <= sub_next;
        div_reg   <= div_next;
        qover_reg <= qover_next;
        dz_reg    <= dz_next;
    end

    assign value = value_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        arith_req.start |-> state_reg == A_IDLE)
        else $error("arith start while busy");

    a_iter_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == A_MUL || state_reg == A_DIV) |-> cnt_reg != '0)
        else $error("iteration counter ran out");

endmodule

// ===== hdl/rpn_stack_evaluator_unit.sv =====
`timescale 1ns / 1ps
// rpn_stack_evaluator_unit: top level with token decode, stack memory, variable bank,
// sticky error and result register; uses rse_pkg and rse_arith
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_type, literal, var_number
//   res      out        res_valid/res_stall   result, error
//
// push literal, push variable, set variable and rejected tokens are handled in the idle state
// add, sub, multiply and divide read both operands (S_RD_R, S_RD_L), then wait in S_ARITH
//   for the one shared adder in rse_arith to finish its iterations; divide by zero skips them
// finish waits in S_FIN while the result register holds an untaken transfer
// reset clears stack pointer, error code, variables and res_valid; stack memory is not cleared
module rpn_stack_evaluator_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  logic [2:0]                              req_type,
    input  logic signed [rse_pkg::VALUE_WIDTH-1:0]  literal,
    input  logic [3:0]                              var_number,
    output logic                                    res_valid,
    input  logic                                    res_stall,
    output logic signed [rse_pkg::VALUE_WIDTH-1:0]  result,
    output logic [1:0]                              error
);
    import rse_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD_R  = 5'b00010,
        S_RD_L  = 5'b00100,
        S_ARITH = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SP_W-1:0]         sp_reg, sp_next;
    err_code_t               err_reg, err_next;
    logic [VALUE_WIDTH-1:0]  var_reg [NUM_VARS];
    logic [VALUE_WIDTH-1:0]  stack_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0]  rd_data_reg;
    logic [VALUE_WIDTH-1:0]  opr_r_reg;
    req_type_t               op_reg;
    logic                    res_valid_reg, res_valid_next;
    logic [VALUE_WIDTH-1:0]  result_reg;
    err_code_t               error_reg;

    logic                    accept;
    req_type_t               req_op;
    logic                    var_ok;
    logic [VAR_IDX_W-1:0]    var_idx;
    logic                    var_we;
    logic                    full;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0]  wr_data;
    logic                    res_load;

    arith_req_t                     arith_req;
    arith_rsp_t                     arith_rsp;
    logic signed [VALUE_WIDTH-1:0]  arith_value;

    rse_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .arith_req (arith_req),
        .lhs       (rd_data_reg),
        .rhs       (opr_r_reg),
        .arith_rsp (arith_rsp),
        .value     (arith_value)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_op    = req_type_t'(req_type);
    assign var_ok    = (var_number != 4'd0) && (var_number <= 4'(NUM_VARS));
    assign var_idx   = VAR_IDX_W'(var_number - 4'd1);
    assign full      = (sp_reg == SP_W'(STACK_DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        err_next        = err_reg;
        rd_addr         = ADDR_W'(sp_reg - SP_W'(1));
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(sp_reg);
        wr_data         = literal;
        var_we          = 1'b0;
        res_load        = 1'b0;
        arith_req.start = 1'b0;
        arith_req.op    = op_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_op)
                        REQ_PUSH_LIT, REQ_PUSH_VAR:
                        begin
                            if (req_op == REQ_PUSH_LIT || var_ok)
                            begin
                                if (full)
                                begin
                                    if (err_reg == ERR_NONE)
                                        err_next = ERR_OVERFLOW;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = (req_op == REQ_PUSH_LIT) ? literal
                                                                       : var_reg[var_idx];
                                    sp_next = sp_reg + SP_W'(1);
                                end
                            end
                        end
                        REQ_SET_VAR:
                        begin
                            var_we = var_ok;
                        end
                        REQ_FINISH:
                        begin
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            if (sp_reg < SP_W'(2))
                            begin
                                if (err_reg == ERR_NONE)
                                    err_next = ERR_UNDERFLOW;
                            end
                            else
                                state_next = S_RD_R;
                        end
                    endcase
                end
            end
            S_RD_R:
            begin
                rd_addr    = ADDR_W'(sp_reg - SP_W'(2));
                state_next = S_RD_L;
            end
            S_RD_L:
            begin
                arith_req.start = 1'b1;
                state_next      = S_ARITH;
            end
            S_ARITH:
            begin
                if (arith_rsp.done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(sp_reg - SP_W'(2));
                    wr_data = arith_value;
                    sp_next = sp_reg - SP_W'(1);
                    if (arith_rsp.div_zero && err_reg == ERR_NONE)
                        err_next = ERR_DIV_ZERO;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_load   = 1'b1;
                    sp_next    = '0;
                    err_next   = ERR_NONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ERR_NONE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_VARS; i++)
                var_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
            if (var_we)
                var_reg[var_idx] <= literal;
        end
    end

    // stack memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= req_op;
        if (state_reg == S_RD_R)
            opr_r_reg <= rd_data_reg;
        if (res_load)
        begin
            result_reg <= (sp_reg != '0) ? rd_data_reg : '0;
            error_reg  <= err_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = result_reg;
    assign error     = error_reg;

    a_sp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside finish");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> (sp_reg == '0 && err_reg == ERR_NONE))
        else $error("finish left stack or error uncleared");

    a_arith_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        arith_rsp.done |-> state_reg == S_ARITH)
        else $error("arith result with no operation pending");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for rpn_stack_evaluator_unit, with a token driver, a result
// monitor and a built-in saturating stack model that predicts every finish transfer
// depends on rse_pkg and the evaluator rtl
module tb_top;
    import rse_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int FRAC_ONE        = 1 << FRAC_BITS;

    typedef logic signed [VALUE_WIDTH-1:0] val_t;

    typedef struct {
        req_type_t       kind;
        val_t            lit;
        logic [3:0]      vnum;
    } token_t;

    typedef struct {
        val_t      value;
        err_code_t code;
    } finish_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       req_valid  = 1'b0;
    logic       req_stall;
    logic [2:0] req_type   = REQ_PUSH_LIT;
    val_t       literal    = '0;
    logic [3:0] var_number = '0;
    logic       res_valid;
    logic       res_stall  = 1'b0;
    val_t       result;
    logic [1:0] error;

    token_t  token_q[$];
    finish_t finish_q[$];
    int      queued_tokens = 0;
    int      send_idle     = 0;
    int      recv_idle     = 0;
    int      fail_count    = 0;
    int      idle_cycles   = 0;

    val_t      stack_mem [STACK_DEPTH];
    int        stack_cnt  = 0;
    val_t      var_bank [NUM_VARS];
    err_code_t sticky_err = ERR_NONE;

    rpn_stack_evaluator_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .literal    (literal),
        .var_number (var_number),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .result     (result),
        .error      (error)
    );

    always #5 clk = ~clk;

    function automatic void raise_err(err_code_t e);
        if (sticky_err == ERR_NONE)
            sticky_err = e;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] abs_val(val_t v);
        return v[VALUE_WIDTH-1] ? -v : v;
    endfunction

    function automatic val_t saturate(logic neg, logic [127:0] mag);
        logic [127:0]           lim;
        logic [VALUE_WIDTH-1:0] m;
        lim = neg ? 128'(NEG_MIN) : 128'(POS_MAX);
        m = (mag > lim) ? lim[VALUE_WIDTH-1:0] : mag[VALUE_WIDTH-1:0];
        return neg ? val_t'(-m) : val_t'(m);
    endfunction

    function automatic val_t add_sat(val_t l, val_t r, logic subtract);
        logic [VALUE_WIDTH+1:0] s;
        logic [VALUE_WIDTH+1:0] le;
        logic [VALUE_WIDTH+1:0] re;
        le = {{2{l[VALUE_WIDTH-1]}}, l};
        re = {{2{r[VALUE_WIDTH-1]}}, r};
        s = subtract ? le - re : le + re;
        if (s[VALUE_WIDTH+1:VALUE_WIDTH-1] == '0 || s[VALUE_WIDTH+1:VALUE_WIDTH-1] == '1)
            return val_t'(s[VALUE_WIDTH-1:0]);
        return s[VALUE_WIDTH+1] ? val_t'(NEG_MIN) : val_t'(POS_MAX);
    endfunction

    function automatic val_t mul_sat(val_t l, val_t r);
        logic [2*VALUE_WIDTH-1:0] p;
        p = {{VALUE_WIDTH{1'b0}}, abs_val(l)} * {{VALUE_WIDTH{1'b0}}, abs_val(r)};
        return saturate(l[VALUE_WIDTH-1] ^ r[VALUE_WIDTH-1], 128'(p >> FRAC_BITS));
    endfunction

    function automatic val_t div_sat(val_t l, val_t r);
        logic [127:0] num;
        logic [127:0] den;
        den = 128'(abs_val(r));
        if (den == '0)
        begin
            raise_err(ERR_DIV_ZERO);
            if (l == '0)
                return '0;
            return l[VALUE_WIDTH-1] ? val_t'(NEG_MIN) : val_t'(POS_MAX);
        end
        num = 128'(abs_val(l)) << FRAC_BITS;
        return saturate(l[VALUE_WIDTH-1] ^ r[VALUE_WIDTH-1], num / den);
    endfunction

    function automatic void push_val(val_t v);
        if (stack_cnt >= STACK_DEPTH)
            raise_err(ERR_OVERFLOW);
        else
        begin
            stack_mem[stack_cnt] = v;
            stack_cnt++;
        end
    endfunction

    // returns 1 when the token yields a finish transfer
    function automatic bit eval_token(token_t t, output finish_t f);
        val_t lhs;
        val_t rhs;
        logic var_ok;
        var_ok = t.vnum >= 1 && t.vnum <= NUM_VARS;
        f.value = '0;
        f.code = ERR_NONE;
        case (t.kind)
            REQ_PUSH_LIT:
                push_val(t.lit);
            REQ_PUSH_VAR:
                if (var_ok)
                    push_val(var_bank[t.vnum - 1]);
            REQ_SET_VAR:
                if (var_ok)
                    var_bank[t.vnum - 1] = t.lit;
            REQ_FINISH:
            begin
                f.value = (stack_cnt > 0) ? stack_mem[stack_cnt - 1] : '0;
                f.code = sticky_err;
                stack_cnt = 0;
                sticky_err = ERR_NONE;
                return 1'b1;
            end
            default:
            begin
                if (stack_cnt < 2)
                    raise_err(ERR_UNDERFLOW);
                else
                begin
                    rhs = stack_mem[stack_cnt - 1];
                    lhs = stack_mem[stack_cnt - 2];
                    stack_cnt -= 2;
                    case (t.kind)
                        REQ_ADD: push_val(add_sat(lhs, rhs, 1'b0));
                        REQ_SUB: push_val(add_sat(lhs, rhs, 1'b1));
                        REQ_MUL: push_val(mul_sat(lhs, rhs));
                        default: push_val(div_sat(lhs, rhs));
                    endcase
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void add_token(req_type_t k, val_t v, logic [3:0] n);
        token_t t;
        t.kind = k;
        t.lit = v;
        t.vnum = n;
        token_q.push_back(t);
        queued_tokens++;
    endfunction

    function automatic val_t rand_val();
        logic [63:0] raw;
        int          k;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(6))
                    0: raw = 64'(POS_MAX);
                    1: raw = 64'(NEG_MIN);
                    2: raw = '0;
                    3: raw = 64'd1;
                    4: raw = '1;
                    5: raw = 64'(FRAC_ONE);
                    default: raw = -64'(FRAC_ONE);
                endcase
            end
            1, 2: ;
            default:
            begin
                k = $urandom_range(4, 34);
                raw = raw & ((64'd1 << k) - 64'd1);
                if ($urandom_range(1) == 1)
                    raw = -raw;
            end
        endcase
        return val_t'(raw[VALUE_WIDTH-1:0]);
    endfunction

    function automatic logic [3:0] rand_var();
        if ($urandom_range(7) == 0)
            return 4'($urandom_range(15));
        return 4'($urandom_range(1, NUM_VARS));
    endfunction

    // mostly well-formed expressions; some deep ones to overflow, some pure noise
    function automatic void gen_program();
        int depth;
        int len;
        int pick;
        bit noise;
        bit deep;
        depth = 0;
        noise = ($urandom_range(9) == 0);
        deep = ($urandom_range(11) == 0);
        len = deep ? $urandom_range(17, 24) : $urandom_range(2, 10);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(9);
            if (noise)
                add_token(req_type_t'($urandom_range(REQ_PUSH_LIT, REQ_SET_VAR)), rand_val(),
                          4'($urandom_range(15)));
            else if (depth < 2 || pick < 4 || (deep && i < 17))
            begin
                if (pick < 7)
                    add_token(REQ_PUSH_LIT, rand_val(), 4'($urandom_range(15)));
                else
                    add_token(REQ_PUSH_VAR, rand_val(), rand_var());
                depth++;
            end
            else if (pick == 4)
                add_token(REQ_SET_VAR, rand_val(), rand_var());
            else
            begin
                add_token(req_type_t'($urandom_range(REQ_ADD, REQ_DIV)), rand_val(),
                          4'($urandom_range(15)));
                depth--;
            end
        end
        add_token(REQ_FINISH, rand_val(), 4'($urandom_range(15)));
    endfunction

    task automatic drain();
        do
            @(negedge clk);
        while (token_q.size() != 0 || req_valid || finish_q.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        token_t  cur;
        finish_t predicted;
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
            begin
                cur.kind = req_type_t'(req_type);
                cur.lit = literal;
                cur.vnum = var_number;
                if (eval_token(cur, predicted))
                    finish_q.push_back(predicted);
            end
            if (!req_valid || !req_stall)
            begin
                if (token_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    cur = token_q[0];
                    token_q.delete(0);
                    req_type <= cur.kind;
                    literal <= cur.lit;
                    var_number <= cur.vnum;
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        finish_t want;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (finish_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected transfer, expected none, got result %h error %0d",
                             $time, result, error);
                end
                else
                begin
                    want = finish_q[0];
                    finish_q.delete(0);
                    if (result !== want.value)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch, expected %h, got %h",
                                 $time, want.value, result);
                    end
                    if (error !== want.code)
                    begin
                        fail_count++;
                        $display("%0t: error mismatch, expected %0d, got %0d",
                                 $time, want.code, error);
                    end
                end
            end
            res_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int send_pct [3];
        int recv_pct [3];
        send_pct = '{20, 76, 0};
        recv_pct = '{76, 20, 0};
        foreach (var_bank[i])
            var_bank[i] = '0;
        foreach (stack_mem[i])
            stack_mem[i] = '0;
        send_idle = send_pct[0];
        recv_idle = recv_pct[0];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty finish, underflow, ignored variables, saturating mul, div by zero
        add_token(REQ_FINISH, '0, 4'd0);
        add_token(REQ_SUB, '0, 4'd0);
        add_token(REQ_SET_VAR, val_t'(NEG_MIN), 4'd1);
        add_token(REQ_SET_VAR, val_t'(5 * FRAC_ONE), 4'd0);
        add_token(REQ_PUSH_VAR, '0, 4'd1);
        add_token(REQ_PUSH_VAR, '0, 4'd15);
        add_token(REQ_PUSH_LIT, val_t'(POS_MAX), 4'd0);
        add_token(REQ_MUL, '0, 4'd0);
        add_token(REQ_PUSH_LIT, '0, 4'd0);
        add_token(REQ_DIV, '0, 4'd0);
        add_token(REQ_FINISH, '0, 4'd0);
        // saturating add, positive over zero
        add_token(REQ_PUSH_LIT, val_t'(POS_MAX), 4'd0);
        add_token(REQ_PUSH_LIT, val_t'(1), 4'd0);
        add_token(REQ_ADD, '0, 4'd0);
        add_token(REQ_PUSH_LIT, '0, 4'd0);
        add_token(REQ_DIV, '0, 4'd0);
        add_token(REQ_FINISH, '0, 4'd0);
        // zero over zero, then subtract a variable
        add_token(REQ_PUSH_LIT, '0, 4'd0);
        add_token(REQ_PUSH_LIT, '0, 4'd0);
        add_token(REQ_DIV, '0, 4'd0);
        add_token(REQ_SET_VAR, '1, 4'(NUM_VARS));
        add_token(REQ_PUSH_VAR, '0, 4'(NUM_VARS));
        add_token(REQ_SUB, '0, 4'd0);
        add_token(REQ_FINISH, '0, 4'd0);

        for (int p = 0; p < 3; p++)
        begin
            send_idle = send_pct[p];
            recv_idle = recv_pct[p];
            while (queued_tokens < (p + 1) * ITEMS_PER_PHASE)
                gen_program();
            drain();
        end

        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rse_pkg.sv
hdl/rse_arith.sv
hdl/rpn_stack_evaluator_unit.sv
dv/tb_top.sv
